// ===== src/gainf_pkg.sv =====
// gainf_pkg: shared types and constants for the green-ampt infiltration solver
// no dependencies; imported by the solver top level
package gainf_pkg;

    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int SAT_W      = 17;
    localparam int TOL_W      = 16;
    localparam int LIMIT_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int LOG_FRAC_W = 30;
    localparam int LOG_W      = 36;
    localparam int PROD_W     = 64;
    localparam int ACC_W      = 68;
    localparam int DIVD_W     = 66;
    localparam int QUOT_W     = 34;

    localparam logic [SAT_W-1:0]   ONE_Q16     = 17'h10000;
    localparam logic [31:0]        LN2_Q30     = 32'd744261118;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd66;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

    typedef enum logic {
        CFG_TOL   = 1'b0,
        CFG_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_MUL_P,
        ST_MUL_KT,
        ST_STEP_START,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_PL_LO,
        ST_PL_HI,
        ST_LN_LO,
        ST_LN_HI,
        ST_PREP,
        ST_MAG_MUL,
        ST_DIV,
        ST_FIN,
        ST_THR,
        ST_DONE
    } state_t;

endpackage

// ===== src/green_ampt_infiltration_solver.sv =====
// green_ampt_infiltration_solver: newton solver for green-ampt cumulative infiltration
// depends on gainf_pkg (types, widths, constants)
//
// usage
// - input channel s_*: one word holds suction head, effective saturation, effective
//   porosity, conductivity and elapsed time; taken when s_valid and s_ready are high
// - result channel m_*: one word per input word with depth, converged flag and the
//   number of newton steps; taken when m_valid and m_ready are high
// - cfg_wr_en/cfg_index/cfg_wdata write the relative tolerance (index 0) and the
//   iteration limit (index 1); write only while the block is idle
// - one word at a time: s_ready is high only in the idle state
// - order of work: the deficit, P and K*T multiplies, then log2 of P (normalise, squaring),
//   then per newton step a start, log2 of P plus depth (normalise, squaring), the ln term
//   and product, the divide and the update, then the done state; a P of zero goes straight
//   to done, and a step on a zero depth skips from its start to the update
// - all arithmetic runs through one 32x32 multiplier, one bit-serial log2 normaliser
//   and a restoring divider that retires one quotient bit per cycle
// - a finished word sits in the output register; the solver waits in its done state
//   while the receiver stalls, so no result is lost
// - reset (aresetn low, synchronous) returns to idle, drops m_valid and restores
//   tolerance 66 and iteration limit 100
module green_ampt_infiltration_solver (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [gainf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gainf_pkg::VALUE_W-1:0]  s_suction_head,
    input  logic [gainf_pkg::SAT_W-1:0]    s_eff_saturation,
    input  logic [gainf_pkg::SAT_W-1:0]    s_eff_porosity,
    input  logic [gainf_pkg::VALUE_W-1:0]  s_conductivity,
    input  logic [gainf_pkg::VALUE_W-1:0]  s_elapsed,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gainf_pkg::VALUE_W-1:0]  m_depth,
    output logic                           m_converged,
    output logic [gainf_pkg::LIMIT_W-1:0]  m_steps_used
);
    import gainf_pkg::*;

    state_t state_reg, state_next;

    // configuration registers
    logic [TOL_W-1:0]   tol_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // captured input word
    logic [VALUE_W-1:0] psi_reg, k_reg, t_reg;
    logic [SAT_W-1:0]   se_reg, th_reg;

    // item constants
    logic [SAT_W-1:0]   d_reg;
    logic [VALUE_W-1:0] p_reg, kt_reg;
    logic [LOG_W-1:0]   lb_reg;

    // newton iterate
    logic [VALUE_W-1:0] f_reg, fnew_reg;
    logic [LIMIT_W-1:0] steps_reg;
    logic               conv_reg;

    // log2 unit
    logic [VALUE_W:0]        w_reg;
    logic [5:0]              exp_reg;
    logic [VALUE_W-1:0]      m_reg;
    logic [LOG_FRAC_W-1:0]   frac_reg;
    logic                    log_s_reg;
    logic [6:0]              cnt_reg;

    // ln term, step magnitude, divider
    logic [ACC_W-1:0]   acc_reg;
    logic [37:0]        x1_reg;
    logic [VALUE_W:0]   s_reg, mag_reg;
    logic               neg_reg;
    logic [DIVD_W-1:0]  num_reg;
    logic [VALUE_W-1:0] rem_reg;
    logic [QUOT_W-1:0]  q_reg;
    logic               qsat_reg;

    // output register
    logic                m_valid_reg;
    logic [VALUE_W-1:0]  m_depth_reg;
    logic                m_conv_reg;
    logic [LIMIT_W-1:0]  m_steps_reg;

    // shared multiplier
    logic [31:0]       mul_a, mul_b;
    logic [PROD_W-1:0] prod;

    // helper terms
    logic [SAT_W-1:0]   se_c, th_c, one_minus_se;
    logic [LOG_W-1:0]   la_val, l_val;
    logic [37:0]        y_val;
    logic [VALUE_W-1:0] pl_val;
    logic [VALUE_W:0]   b_val;
    logic [VALUE_W:0]   cross_val;
    logic [DIVD_W-1:0]  num_val;
    logic [VALUE_W:0]   r2_val, r2_sub;
    logic               r2_ge;
    logic [QUOT_W-1:0]  step_val;
    logic [VALUE_W-1:0] fstep_val, diff_val, lo_val, thr_val;
    logic [LIMIT_W-1:0] steps_inc;
    logic               conv_val;
    logic [VALUE_W:0]   sq_top;

    // fractions above one count as one
    assign se_c         = (se_reg > ONE_Q16) ? ONE_Q16 : se_reg;
    assign th_c         = (th_reg > ONE_Q16) ? ONE_Q16 : th_reg;
    assign one_minus_se = ONE_Q16 - se_c;

    // log difference, never negative
    assign la_val = {exp_reg, frac_reg};
    assign l_val  = (la_val > lb_reg) ? (la_val - lb_reg) : '0;

    // P*ln term after the second scaling, saturated to full scale
    assign y_val  = acc_reg[ACC_W-1:LOG_FRAC_W];
    assign pl_val = (|y_val[37:32]) ? '1 : y_val[31:0];
    assign b_val  = {1'b0, kt_reg} + {1'b0, pl_val};

    // 33x33 product from the 32x32 low part plus single-bit cross terms
    assign cross_val = (mag_reg[VALUE_W] ? {1'b0, s_reg[VALUE_W-1:0]} : '0)
                     + (s_reg[VALUE_W] ? {1'b0, mag_reg[VALUE_W-1:0]} : '0);
    assign num_val = {2'b0, prod} + {1'b0, cross_val, 32'b0}
                   + {1'b0, mag_reg[VALUE_W] & s_reg[VALUE_W], 64'b0};

    // restoring divide, one quotient bit per cycle
    assign r2_val = {rem_reg, num_reg[DIVD_W-1]};
    assign r2_ge  = (r2_val >= {1'b0, f_reg});
    assign r2_sub = r2_val - {1'b0, f_reg};

    // newton update, clamped to the value range
    assign step_val = qsat_reg ? '1 : q_reg;
    always_comb begin
        if (!neg_reg) begin
            fstep_val = (step_val >= {2'b0, f_reg}) ? '0 : (f_reg - step_val[VALUE_W-1:0]);
        end else begin
            fstep_val = (step_val > {2'b0, ~f_reg}) ? '1 : (f_reg + step_val[VALUE_W-1:0]);
        end
    end

    // convergence test
    assign diff_val  = (fnew_reg >= f_reg) ? (fnew_reg - f_reg) : (f_reg - fnew_reg);
    assign lo_val    = (fnew_reg < f_reg) ? fnew_reg : f_reg;
    assign thr_val   = prod[47:16];
    assign conv_val  = (diff_val < thr_val) || (diff_val == '0);
    assign steps_inc = steps_reg + 8'd1;

    // squared mantissa, Q2.31 kept to 33 bits
    assign sq_top = prod[63:31];

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_D: begin
                mul_a = {15'b0, one_minus_se};
                mul_b = {15'b0, th_c};
            end
            ST_MUL_P: begin
                mul_a = psi_reg;
                mul_b = {15'b0, d_reg};
            end
            ST_MUL_KT: begin
                mul_a = k_reg;
                mul_b = t_reg;
            end
            ST_LOG_SQ: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_PL_LO: begin
                mul_a = p_reg;
                mul_b = l_val[31:0];
            end
            ST_PL_HI: begin
                mul_a = p_reg;
                mul_b = {28'b0, l_val[35:32]};
            end
            ST_LN_LO: begin
                mul_a = acc_reg[61:30];
                mul_b = LN2_Q30;
            end
            ST_LN_HI: begin
                mul_a = {26'b0, x1_reg[37:32]};
                mul_b = LN2_Q30;
            end
            ST_MAG_MUL: begin
                mul_a = mag_reg[VALUE_W-1:0];
                mul_b = s_reg[VALUE_W-1:0];
            end
            ST_THR: begin
                mul_a = {16'b0, tol_reg};
                mul_b = lo_val;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_valid) state_next = ST_MUL_D;
            ST_MUL_D:      state_next = ST_MUL_P;
            ST_MUL_P:      state_next = ST_MUL_KT;
            ST_MUL_KT:     state_next = (p_reg == '0) ? ST_DONE : ST_LOG_NORM;
            ST_STEP_START: state_next = (f_reg == '0) ? ST_THR : ST_LOG_NORM;
            ST_LOG_NORM:   if (w_reg[VALUE_W]) state_next = ST_LOG_SQ;
            ST_LOG_SQ: begin
                if (cnt_reg == '0) state_next = log_s_reg ? ST_PL_LO : ST_STEP_START;
            end
            ST_PL_LO:      state_next = ST_PL_HI;
            ST_PL_HI:      state_next = ST_LN_LO;
            ST_LN_LO:      state_next = ST_LN_HI;
            ST_LN_HI:      state_next = ST_PREP;
            ST_PREP:       state_next = ST_MAG_MUL;
            ST_MAG_MUL:    state_next = ST_DIV;
            ST_DIV:        if (cnt_reg == '0) state_next = ST_FIN;
            ST_FIN:        state_next = ST_THR;
            ST_THR: begin
                if (conv_val || (steps_inc >= limit_reg)) state_next = ST_DONE;
                else state_next = ST_STEP_START;
            end
            ST_DONE:       if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
    end

    assign m_valid      = m_valid_reg;
    assign m_depth      = m_depth_reg;
    assign m_converged  = m_conv_reg;
    assign m_steps_used = m_steps_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tol_reg     <= TOL_RESET;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_TOL:   tol_reg   <= cfg_wdata[TOL_W-1:0];
                    CFG_LIMIT: limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    default:   tol_reg   <= tol_reg;
                endcase
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                psi_reg <= s_suction_head;
                se_reg  <= s_eff_saturation;
                th_reg  <= s_eff_porosity;
                k_reg   <= s_conductivity;
                t_reg   <= s_elapsed;
            end
            ST_MUL_D: d_reg <= prod[32:16];
            ST_MUL_P: p_reg <= prod[47:16];
            ST_MUL_KT: begin
                kt_reg    <= (|prod[63:48]) ? '1 : prod[47:16];
                f_reg     <= (|prod[63:48]) ? '1 : prod[47:16];
                steps_reg <= '0;
                conv_reg  <= 1'b1;
                w_reg     <= {1'b0, p_reg};
                exp_reg   <= 6'd32;
                log_s_reg <= 1'b0;
            end
            ST_STEP_START: begin
                fnew_reg  <= '0;
                s_reg     <= {1'b0, p_reg} + {1'b0, f_reg};
                w_reg     <= {1'b0, p_reg} + {1'b0, f_reg};
                exp_reg   <= 6'd32;
                log_s_reg <= 1'b1;
            end
            ST_LOG_NORM: begin
                if (w_reg[VALUE_W]) begin
                    m_reg   <= w_reg[VALUE_W:1];
                    cnt_reg <= 7'(LOG_FRAC_W - 1);
                end else begin
                    w_reg   <= {w_reg[VALUE_W-1:0], 1'b0};
                    exp_reg <= exp_reg - 6'd1;
                end
            end
            ST_LOG_SQ: begin
                m_reg    <= sq_top[VALUE_W] ? sq_top[VALUE_W:1] : sq_top[VALUE_W-1:0];
                frac_reg <= {frac_reg[LOG_FRAC_W-2:0], sq_top[VALUE_W]};
                cnt_reg  <= cnt_reg - 7'd1;
                if (cnt_reg == '0 && !log_s_reg) begin
                    lb_reg <= {exp_reg, frac_reg[LOG_FRAC_W-2:0], sq_top[VALUE_W]};
                end
            end
            ST_PL_LO: acc_reg <= {4'b0, prod};
            ST_PL_HI: acc_reg <= acc_reg + {prod[35:0], 32'b0};
            ST_LN_LO: begin
                x1_reg  <= acc_reg[ACC_W-1:LOG_FRAC_W];
                acc_reg <= {4'b0, prod};
            end
            ST_LN_HI: acc_reg <= acc_reg + {prod[35:0], 32'b0};
            ST_PREP: begin
                if ({1'b0, f_reg} >= b_val) begin
                    mag_reg <= {1'b0, f_reg} - b_val;
                    neg_reg <= 1'b0;
                end else begin
                    mag_reg <= b_val - {1'b0, f_reg};
                    neg_reg <= 1'b1;
                end
            end
            ST_MAG_MUL: begin
                num_reg  <= num_val;
                rem_reg  <= '0;
                q_reg    <= '0;
                qsat_reg <= 1'b0;
                cnt_reg  <= 7'(DIVD_W - 1);
            end
            ST_DIV: begin
                rem_reg  <= r2_ge ? r2_sub[VALUE_W-1:0] : r2_val[VALUE_W-1:0];
                q_reg    <= {q_reg[QUOT_W-2:0], r2_ge};
                qsat_reg <= qsat_reg | q_reg[QUOT_W-1];
                num_reg  <= {num_reg[DIVD_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 7'd1;
            end
            ST_FIN: fnew_reg <= fstep_val;
            ST_THR: begin
                f_reg     <= fnew_reg;
                conv_reg  <= conv_val;
                steps_reg <= steps_inc;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_depth_reg <= f_reg;
                    m_conv_reg  <= conv_reg;
                    m_steps_reg <= steps_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // divider remainder always stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < f_reg))
        else $error("divider remainder not below divisor");

    // squaring mantissa stays normalised
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOG_SQ) |-> m_reg[VALUE_W-1])
        else $error("log2 mantissa lost its leading one");

    // a result with no newton step is always reported as converged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_steps_used == '0) |-> m_converged)
        else $error("zero-step result not flagged converged");

endmodule

// ===== tb/green_ampt_infiltration_solver_tb.sv =====
// green_ampt_infiltration_solver_tb: self-checking bench for the green-ampt newton solver
// depends on gainf_pkg and green_ampt_infiltration_solver; predicts each result in-bench
`timescale 1ns / 100ps

module green_ampt_infiltration_solver_tb;
    import gainf_pkg::*;

    localparam logic [63:0] FULL_SCALE = 64'hFFFF_FFFF;
    localparam longint CYCLE_LIMIT = 120_000_000;

    typedef struct packed {
        logic [VALUE_W-1:0] depth;
        logic               converged;
        logic [LIMIT_W-1:0] steps;
    } solution_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_W-1:0]    s_suction_head = '0;
    logic [SAT_W-1:0]      s_eff_saturation = '0;
    logic [SAT_W-1:0]      s_eff_porosity = '0;
    logic [VALUE_W-1:0]    s_conductivity = '0;
    logic [VALUE_W-1:0]    s_elapsed = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [VALUE_W-1:0]    m_depth;
    logic                  m_converged;
    logic [LIMIT_W-1:0]    m_steps_used;

    // bench copy of the two registers
    logic [TOL_W-1:0]   tol_reg = TOL_RESET;
    logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

    solution_t pending_solutions[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    longint    cycle_count = 0;

    green_ampt_infiltration_solver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_suction_head  (s_suction_head),
        .s_eff_saturation(s_eff_saturation),
        .s_eff_porosity  (s_eff_porosity),
        .s_conductivity  (s_conductivity),
        .s_elapsed       (s_elapsed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_depth         (m_depth),
        .m_converged     (m_converged),
        .m_steps_used    (m_steps_used)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // log2 in q.30: top bit index plus 30 rounds of mantissa squaring
    function automatic logic [63:0] log2_q30(logic [63:0] x);
        int          n;
        logic [63:0] mant;
        logic [63:0] acc;
        logic [127:0] sq;
        if (x == 0) return 64'd0;
        n = 63;
        while (!x[n]) n--;
        mant = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
        acc = 64'(n) << LOG_FRAC_W;
        for (int i = LOG_FRAC_W - 1; i >= 0; i--) begin
            sq = 128'(mant) * 128'(mant);
            mant = 64'(sq >> 31);
            if (mant >= 64'h1_0000_0000) begin
                mant = mant >> 1;
                acc[i] = 1'b1;
            end
        end
        return acc;
    endfunction

    // one newton update of the depth
    function automatic logic [63:0] newton_update(logic [63:0] f_cur, logic [63:0] p,
                                                  logic [63:0] kt);
        logic [63:0]  sum_pf;
        logic [63:0]  log_a;
        logic [63:0]  log_b;
        logic [63:0]  log_diff;
        logic [127:0] wide;
        logic [63:0]  p_ln;
        logic [63:0]  rhs;
        logic [63:0]  mag;
        logic         neg;
        logic [63:0]  delta;
        if (f_cur == 0) return 64'd0;
        sum_pf = p + f_cur;
        log_a = log2_q30(sum_pf);
        log_b = log2_q30(p);
        log_diff = (log_a > log_b) ? log_a - log_b : 64'd0;
        wide = (128'(p) * 128'(log_diff)) >> LOG_FRAC_W;
        wide = (wide * 128'(LN2_Q30)) >> LOG_FRAC_W;
        p_ln = (wide > 128'(FULL_SCALE)) ? FULL_SCALE : 64'(wide);
        rhs = kt + p_ln;
        neg = (f_cur < rhs);
        mag = neg ? rhs - f_cur : f_cur - rhs;
        wide = (128'(mag) * 128'(sum_pf)) / 128'(f_cur);
        delta = (wide > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(wide);
        if (!neg) return (delta >= f_cur) ? 64'd0 : f_cur - delta;
        if (delta > FULL_SCALE - f_cur) return FULL_SCALE;
        return f_cur + delta;
    endfunction

    function automatic solution_t solve_depth(logic [31:0] psi, logic [16:0] se,
                                              logic [16:0] theta, logic [31:0] cond,
                                              logic [31:0] elapsed);
        solution_t   sol;
        logic [63:0] se_c;
        logic [63:0] th_c;
        logic [63:0] deficit;
        logic [63:0] p;
        logic [63:0] kt;
        logic [63:0] f_cur;
        logic [63:0] f_new;
        logic [63:0] diff;
        logic [63:0] lo_f;
        logic [127:0] thr;
        int          steps;
        logic        conv;
        se_c = (se > ONE_Q16) ? 64'(ONE_Q16) : 64'(se);
        th_c = (theta > ONE_Q16) ? 64'(ONE_Q16) : 64'(theta);
        deficit = ((64'(ONE_Q16) - se_c) * th_c) >> 16;
        p = (64'(psi) * deficit) >> 16;
        kt = (64'(cond) * 64'(elapsed)) >> FRAC_W;
        if (kt > FULL_SCALE) kt = FULL_SCALE;
        if (p == 0) begin
            sol.depth = kt[31:0];
            sol.converged = 1'b1;
            sol.steps = '0;
            return sol;
        end
        f_cur = kt;
        steps = 0;
        // a zero limit still runs one step
        do begin
            steps++;
            f_new = newton_update(f_cur, p, kt);
            diff = (f_new >= f_cur) ? f_new - f_cur : f_cur - f_new;
            lo_f = (f_new < f_cur) ? f_new : f_cur;
            thr = (128'(tol_reg) * 128'(lo_f)) >> 16;
            conv = (128'(diff) < thr) || (diff == 0);
            f_cur = f_new;
        end while (!conv && steps < int'(limit_reg));
        sol.depth = f_cur[31:0];
        sol.converged = conv;
        sol.steps = steps[7:0];
        return sol;
    endfunction

    // receiver: random stalls on m_ready
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker: compare each accepted word with the oldest prediction
    always @(posedge aclk) begin
        solution_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_solutions.size() == 0) begin
                $error("unexpected result word: depth %0h", m_depth);
                mismatches++;
            end else begin
                want = pending_solutions.pop_front();
                if (m_depth !== want.depth) begin
                    $error("depth: expected %0h actual %0h", want.depth, m_depth);
                    mismatches++;
                end
                if (m_converged !== want.converged) begin
                    $error("converged: expected %0b actual %0b", want.converged, m_converged);
                    mismatches++;
                end
                if (m_steps_used !== want.steps) begin
                    $error("steps_used: expected %0d actual %0d", want.steps, m_steps_used);
                    mismatches++;
                end
            end
        end
    end

    // send one word; valid stays high afterwards unless the next call idles
    task automatic send_word(logic [31:0] psi, logic [16:0] se, logic [16:0] theta,
                             logic [31:0] cond, logic [31:0] elapsed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_suction_head <= psi;
        s_eff_saturation <= se;
        s_eff_porosity <= theta;
        s_conductivity <= cond;
        s_elapsed <= elapsed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_solutions.push_back(solve_depth(psi, se, theta, cond, elapsed));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_solutions.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // register write, only once the solver has gone quiet
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_TOL) tol_reg = value;
        else limit_reg = value[LIMIT_W-1:0];
    endtask

    task automatic send_random_word();
        logic [31:0] psi;
        logic [16:0] se;
        logic [16:0] theta;
        logic [31:0] cond;
        logic [31:0] elapsed;
        if ($urandom_range(99) < 25) begin
            // raw bit noise over the whole field widths
            psi = $urandom;
            se = 17'($urandom);
            theta = 17'($urandom);
            cond = $urandom;
            elapsed = $urandom;
        end else begin
            psi = $urandom_range(32'h0040_0000);
            se = 17'($urandom_range(32'h1_0000));
            theta = 17'($urandom_range(32'h1_0000));
            cond = $urandom_range(32'h0008_0000);
            elapsed = $urandom_range(32'h0100_0000);
        end
        send_word(psi, se, theta, cond, elapsed);
    endtask

    task automatic test_directed();
        send_word(32'h0, 17'h0, 17'h1_0000, 32'h1_0000, 32'h1_0000);        // zero suction
        send_word(32'h5_0000, 17'h1_0000, 17'h8000, 32'h1_0000, 32'h2_0000); // no deficit
        send_word(32'h5_0000, 17'h1_FFFF, 17'h8000, 32'h1_0000, 32'h2_0000); // saturation over one
        send_word(32'h5_0000, 17'h4000, 17'h1_FFFF, 32'h1_0000, 32'h2_0000); // porosity over one
        send_word(32'h5_0000, 17'h4000, 17'h0, 32'h1_0000, 32'h2_0000);      // zero porosity
        send_word(32'h5_0000, 17'h0, 17'h1_0000, 32'h0, 32'h2_0000);         // zero conductivity
        send_word(32'h5_0000, 17'h0, 17'h1_0000, 32'h1_0000, 32'h0);         // zero time
        send_word(32'hFFFF_FFFF, 17'h0, 17'h1_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 17'h0, 17'h1_0000, 32'h1, 32'h1);
        send_word(32'h1, 17'h0, 17'h1_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h1, 17'hFFFF, 17'h1, 32'h1, 32'h1_0000);
        send_word(32'h0011_0000, 17'h3000, 17'h7000, 32'h0000_4000, 32'h0004_0000);
        send_word(32'h0100_0000, 17'h8000, 17'hC000, 32'h0000_0100, 32'h0000_0100);
        send_word(32'h0000_8000, 17'h1000, 17'hF000, 32'h0010_0000, 32'h0100_0000);
    endtask

    // settings swept: extremes of both registers, zero limit and zero tolerance
    task automatic test_config_sweep();
        logic [CFG_DATA_W-1:0] tols[5]   = '{16'd1, 16'd65535, 16'd0, 16'd66, 16'd3000};
        logic [CFG_DATA_W-1:0] limits[5] = '{16'd1, 16'd255, 16'd0, 16'd2, 16'd100};
        for (int i = 0; i < 5; i++) begin
            write_reg(CFG_TOL, tols[i]);
            write_reg(CFG_LIMIT, limits[i]);
            repeat (30) send_random_word();
            send_word(32'h0011_0000, 17'h3000, 17'h7000, 32'h0000_4000, 32'h0004_0000);
        end
    endtask

    task automatic test_random(int count);
        int idle_tab[4]  = '{0, 51, 0, 33};
        int stall_tab[4] = '{0, 0, 51, 33};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            repeat (count / 4) send_random_word();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_sweep();
        write_reg(CFG_TOL, TOL_RESET);
        write_reg(CFG_LIMIT, 16'(LIMIT_RESET));
        test_random(1300);
        drain_results();
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && pending_solutions.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
